### hw/rtl/limited_linear_upwind_face_correction_unit_assert.svh
// Assertion macros for the limited linear-upwind face correction unit.
`ifndef LIMITED_LINEAR_UPWIND_FACE_CORRECTION_UNIT_ASSERT_SVH
`define LIMITED_LINEAR_UPWIND_FACE_CORRECTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/llu_pkg.sv
// Package: constants, field layout and result codes for the face correction unit.
package llu_pkg;

    localparam int COMPONENT_WIDTH_DEF = 21;
    localparam int FRACTION_BITS_DEF   = 10;

    // Weight format: unsigned Q1.16, one is 2^16
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_W    = WEIGHT_BITS + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;

    // Packed vector field width on the ports
    localparam int VEC_W = 63;

    // Input word layout, lowest bit first
    localparam int OFS_WEIGHT = 0;
    localparam int OFS_OWN    = OFS_WEIGHT + WEIGHT_W;
    localparam int OFS_NEI    = OFS_OWN + VEC_W;
    localparam int OFS_FACE   = OFS_NEI + VEC_W;
    localparam int OFS_UPW    = OFS_FACE + VEC_W;
    localparam int OFS_GX     = OFS_UPW + VEC_W;
    localparam int OFS_GY     = OFS_GX + VEC_W;
    localparam int OFS_GZ     = OFS_GY + VEC_W;
    localparam int IN_BITS    = OFS_GZ + VEC_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VEC_W + 7) / 8) * 8;

    // Result kind
    typedef enum logic [1:0] {
        CLIP_NONE  = 2'd0,
        CLIP_ZERO  = 2'd1,
        CLIP_SCALE = 2'd2
    } clip_t;

endpackage

### hw/rtl/limited_linear_upwind_face_correction_unit.sv
// Limited linear-upwind face correction: d*G correction, bound, sign/ratio limiter.
//
// Usage:
//   Slave channel takes one mesh face per word: s_tuser carries the flux
//   sign flag, s_tdata the weight, owner/neighbour values, face centre,
//   upwind centre and the three gradient rows. Master channel returns one
//   word per face: the limited correction in m_tdata and the limiter
//   outcome in m_tuser (none, zeroed, scaled).
//   The pipeline has five arithmetic stages, one limiter decision stage,
//   one restoring divider stage per quotient bit, and the output register.
//   Throughput is one face per cycle while m_tready is high; the divider
//   is fully unrolled, one quotient bit per stage.
//   Every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and s_tready stays high
//   while any stage is free, even with a result held at the output.
//   When m_tready is low the output word holds and the pipeline fills up;
//   nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) clears all valid bits; the data
//   registers are not reset and there is no configuration.
module limited_linear_upwind_face_correction_unit #(
    parameter int COMPONENT_WIDTH = llu_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = llu_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // weight, owner_value, neighbour_value, face_centre, upwind_centre,
    // gradient_row_x, gradient_row_y, gradient_row_z, zero pad
    input  logic [llu_pkg::S_TDATA_W-1:0]   s_tdata,
    // flux_positive
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // correction, zero pad
    output logic [llu_pkg::M_TDATA_W-1:0]   m_tdata,
    // was_clipped
    output logic [1:0]                      m_tuser
);
    import llu_pkg::*;

    `include "limited_linear_upwind_face_correction_unit_assert.svh"

    localparam int CW  = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int DW  = CW + 1;                 // displacement / difference
    localparam int PW  = DW + CW;                // d * G product
    localparam int BPW = DW + WEIGHT_W + 1;      // factor * difference
    localparam int XW  = PW + BPW + 4;           // common width before saturation
    localparam int QW  = 2 * CW;                 // c*c and c*b products
    localparam int MW  = QW + 3;                 // s and m sums
    localparam int SW  = QW + 1;                 // s as unsigned
    localparam int TW  = SW + 2;                 // divider partial remainder
    localparam int DIV0 = 5;                     // stage index of limiter decision
    localparam int NST  = CW + 7;                // total stages including output
    localparam int OUTS = NST - 1;

    localparam logic signed [XW-1:0] CMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] CMIN = ~CMAX;
    localparam logic signed [XW-1:0] HALF_C = XW'(1) << (F - 1);
    localparam logic signed [XW-1:0] HALF_B = XW'(1) << (WEIGHT_BITS - 1);

    function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
        if (v > CMAX) return CMAX[CW-1:0];
        if (v < CMIN) return CMIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stage control: valid per stage, load when empty or downstream moves
    // ------------------------------------------------------------------
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;

    always_comb begin
        en[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];

    // ------------------------------------------------------------------
    // Stage 1: unpack, displacement, bound factor and difference
    // ------------------------------------------------------------------
    logic signed [DW-1:0]       d_reg [3];
    logic signed [CW-1:0]       g_reg [3][3];
    logic signed [DW-1:0]       diff_reg [3];
    logic [WEIGHT_W-1:0]        f_reg;
    logic [WEIGHT_W-1:0]        w_clamp;

    always_comb begin
        w_clamp = s_tdata[OFS_WEIGHT +: WEIGHT_W];
        if (w_clamp > WEIGHT_ONE) w_clamp = WEIGHT_ONE;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            f_reg <= s_tuser[0] ? (WEIGHT_ONE - w_clamp) : w_clamp;
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= DW'($signed(s_tdata[OFS_FACE + i*CW +: CW]))
                          - DW'($signed(s_tdata[OFS_UPW + i*CW +: CW]));
                diff_reg[i] <= s_tuser[0]
                    ? DW'($signed(s_tdata[OFS_NEI + i*CW +: CW]))
                      - DW'($signed(s_tdata[OFS_OWN + i*CW +: CW]))
                    : DW'($signed(s_tdata[OFS_OWN + i*CW +: CW]))
                      - DW'($signed(s_tdata[OFS_NEI + i*CW +: CW]));
                g_reg[0][i] <= $signed(s_tdata[OFS_GX + i*CW +: CW]);
                g_reg[1][i] <= $signed(s_tdata[OFS_GY + i*CW +: CW]);
                g_reg[2][i] <= $signed(s_tdata[OFS_GZ + i*CW +: CW]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine d*G products and three bound products
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  p_reg [3][3];
    logic signed [BPW-1:0] bp_reg [3];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[i][j] <= d_reg[i] * g_reg[i][j];
                end
                bp_reg[i] <= $signed({1'b0, f_reg}) * diff_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, round to nearest, saturate
    // ------------------------------------------------------------------
    logic signed [CW-1:0] c3_reg [3];
    logic signed [CW-1:0] b3_reg [3];
    logic signed [XW-1:0] acc_c [3];
    logic signed [XW-1:0] acc_b [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            acc_c[j] = (XW'(p_reg[0][j]) + XW'(p_reg[1][j]) + XW'(p_reg[2][j])
                        + HALF_C) >>> F;
            acc_b[j] = (XW'(bp_reg[j]) + HALF_B) >>> WEIGHT_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int j = 0; j < 3; j++) begin
                c3_reg[j] <= sat_c(acc_c[j]);
                b3_reg[j] <= sat_c(acc_b[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: c*c and c*b products
    // ------------------------------------------------------------------
    logic signed [QW-1:0] cc_reg [3];
    logic signed [QW-1:0] cb_reg [3];
    logic signed [CW-1:0] c4_reg [3];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int j = 0; j < 3; j++) begin
                cc_reg[j] <= c3_reg[j] * c3_reg[j];
                cb_reg[j] <= c3_reg[j] * b3_reg[j];
                c4_reg[j] <= c3_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squared magnitude s and projection m
    // ------------------------------------------------------------------
    logic signed [MW-1:0] s_reg;
    logic signed [MW-1:0] m_reg;
    logic signed [CW-1:0] c5_reg [3];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s_reg <= MW'(cc_reg[0]) + MW'(cc_reg[1]) + MW'(cc_reg[2]);
            m_reg <= MW'(cb_reg[0]) + MW'(cb_reg[1]) + MW'(cb_reg[2]);
            for (int j = 0; j < 3; j++) c5_reg[j] <= c4_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: index 0 is the limiter decision, 1..CW one bit each.
    // q = floor(|c| * m / s), |c| fed MSB first: r = 2r + bit*m, digit 0..2
    // ------------------------------------------------------------------
    logic [SW-1:0]        ds_reg   [CW+1];
    logic [SW-1:0]        dm_reg   [CW+1];
    clip_t                dmode_reg[CW+1];
    logic signed [CW-1:0] dc_reg   [CW+1][3];
    logic [CW-1:0]        dmag_reg [CW+1][3];
    logic [SW-1:0]        dr_reg   [CW+1][3];
    logic [CW-1:0]        dq_reg   [CW+1][3];

    clip_t mode0;

    always_comb begin
        if (s_reg != '0 && m_reg[MW-1]) begin
            mode0 = CLIP_ZERO;
        end else if (s_reg != '0 && s_reg > m_reg) begin
            mode0 = CLIP_SCALE;
        end else begin
            mode0 = CLIP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DIV0]) begin
            ds_reg[0]    <= s_reg[SW-1:0];
            dm_reg[0]    <= m_reg[SW-1:0];
            dmode_reg[0] <= mode0;
            for (int j = 0; j < 3; j++) begin
                dc_reg[0][j]   <= c5_reg[j];
                dmag_reg[0][j] <= c5_reg[j][CW-1] ? (~c5_reg[j] + CW'(1)) : c5_reg[j];
                dr_reg[0][j]   <= '0;
                dq_reg[0][j]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= CW; k++) begin : g_div
        logic [TW-1:0] t   [3];
        logic [TW-1:0] s1;
        logic [TW-1:0] s2;
        logic [1:0]    dig [3];
        logic [SW-1:0] rn  [3];

        always_comb begin
            s1 = TW'(ds_reg[k-1]);
            s2 = s1 << 1;
            for (int j = 0; j < 3; j++) begin
                t[j] = (TW'(dr_reg[k-1][j]) << 1)
                     + (dmag_reg[k-1][j][CW-k] ? TW'(dm_reg[k-1]) : '0);
                if (t[j] >= s2) begin
                    dig[j] = 2'd2;
                    rn[j]  = SW'(t[j] - s2);
                end else if (t[j] >= s1) begin
                    dig[j] = 2'd1;
                    rn[j]  = SW'(t[j] - s1);
                end else begin
                    dig[j] = 2'd0;
                    rn[j]  = SW'(t[j]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[DIV0+k]) begin
                ds_reg[k]    <= ds_reg[k-1];
                dm_reg[k]    <= dm_reg[k-1];
                dmode_reg[k] <= dmode_reg[k-1];
                for (int j = 0; j < 3; j++) begin
                    dc_reg[k][j]   <= dc_reg[k-1][j];
                    dmag_reg[k][j] <= dmag_reg[k-1][j];
                    dr_reg[k][j]   <= rn[j];
                    dq_reg[k][j]   <= (dq_reg[k-1][j] << 1) + CW'(dig[j]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: select result and pack
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [1:0]            out_user_reg;
    logic signed [CW-1:0]  res [3];
    logic [M_TDATA_W-1:0]  packed_res;

    always_comb begin
        packed_res = '0;
        for (int j = 0; j < 3; j++) begin
            case (dmode_reg[CW])
                CLIP_ZERO:  res[j] = '0;
                CLIP_SCALE: res[j] = dc_reg[CW][j][CW-1] ? -dq_reg[CW][j] : dq_reg[CW][j];
                default:    res[j] = dc_reg[CW][j];
            endcase
            packed_res[j*CW +: CW] = res[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[OUTS]) begin
            out_data_reg <= packed_res;
            out_user_reg <= dmode_reg[CW];
        end
    end

    assign m_tvalid = v_reg[OUTS];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LLU_ASSERT_IMPL(a_full_only_on_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled while a stage was free")
    `LLU_ASSERT_IMPL(a_zeroed_is_zero, aclk, aresetn, m_tvalid && m_tuser == CLIP_ZERO, m_tdata == '0, "zeroed result carries data")
    `LLU_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:3*CW] == '0, "bits above the packed vector are set")
    `LLU_ASSERT_NEXT(a_take_moves, aclk, aresetn, s_tvalid && s_tready, v_reg[0], "accepted word not captured")

endmodule

### tb/limited_linear_upwind_face_correction_unit_test.sv
// Self-checking testbench for the limited linear-upwind face correction unit.
`timescale 1ns / 1ps

module limited_linear_upwind_face_correction_unit_test;
    import llu_pkg::*;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int FB = FRACTION_BITS_DEF;

    // One face: vecs holds own, nei, face, upwind, gx, gy, gz (index 0 lowest)
    typedef struct {
        logic              flux_pos;
        logic [WEIGHT_W-1:0] weight;
        logic [6:0][VEC_W-1:0] vecs;
    } face_t;

    typedef struct {
        logic [M_TDATA_W-1:0] corr;
        clip_t                kind;
    } corr_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    corr_t expected_corr[$];
    int    error_count = 0;
    int    burst_left = 0;
    int    max_gap = 6;
    int    hold_cycles = 0;
    int    stall_mode = 0;
    int    stall_count = 0;

    always #5 aclk = ~aclk;

    limited_linear_upwind_face_correction_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Signed component k of a packed vector
    function automatic longint comp(input logic [VEC_W-1:0] v, input int k);
        logic signed [CW-1:0] r;
        r = v[k*CW +: CW];
        return longint'(r);
    endfunction

    function automatic longint sat_comp(input longint v);
        longint hi, lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -(longint'(1) << (CW - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
        logic [VEC_W-1:0] v;
        v = '0;
        v[0 +: CW] = x[CW-1:0];
        v[CW +: CW] = y[CW-1:0];
        v[2*CW +: CW] = z[CW-1:0];
        return v;
    endfunction

    // Expected limited correction for one face
    function automatic corr_t limit_correction(input face_t f);
        longint d[3], c[3], b[3];
        longint acc, prod, s, m, w, own, nei;
        longint unsigned mag, q;
        corr_t r;
        s = 0;
        m = 0;
        w = (f.weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(f.weight);
        for (int i = 0; i < 3; i++)
            d[i] = comp(f.vecs[2], i) - comp(f.vecs[3], i);
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += d[i] * comp(f.vecs[4 + i], j);
            c[j] = sat_comp((acc + (longint'(1) << (FB - 1))) >>> FB);
        end
        for (int j = 0; j < 3; j++) begin
            own = comp(f.vecs[0], j);
            nei = comp(f.vecs[1], j);
            prod = f.flux_pos ? (longint'(WEIGHT_ONE) - w) * (nei - own) : w * (own - nei);
            b[j] = sat_comp((prod + (longint'(1) << (WEIGHT_BITS - 1))) >>> WEIGHT_BITS);
        end
        for (int j = 0; j < 3; j++) begin
            s += c[j] * c[j];
            m += c[j] * b[j];
        end
        r.kind = CLIP_NONE;
        if (s > 0) begin
            if (m < 0) begin
                for (int j = 0; j < 3; j++) c[j] = 0;
                r.kind = CLIP_ZERO;
            end else if (s > m) begin
                for (int j = 0; j < 3; j++) begin
                    mag = (c[j] < 0) ? -c[j] : c[j];
                    q = (mag * longint'(m)) / longint'(s);
                    c[j] = (c[j] < 0) ? -longint'(q) : longint'(q);
                end
                r.kind = CLIP_SCALE;
            end
        end
        r.corr = '0;
        for (int j = 0; j < 3; j++)
            r.corr[j*CW +: CW] = c[j][CW-1:0];
        return r;
    endfunction

    // Offer one face in bursts with random gaps; wait for acceptance
    task automatic send_face(input face_t f);
        logic ok;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - IN_BITS){1'b0}}, f.vecs, f.weight};
        s_tuser  <= f.flux_pos;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        expected_corr.push_back(limit_correction(f));
        burst_left--;
    endtask

    function automatic logic [VEC_W-1:0] rand_vec(input int mag_bits);
        logic [VEC_W-1:0] v;
        int r;
        v = VEC_W'({$urandom, $urandom});
        if (mag_bits < CW - 1) begin
            for (int k = 0; k < 3; k++) begin
                r = $urandom;
                r = r >>> (31 - mag_bits);
                v[k*CW +: CW] = r[CW-1:0];
            end
        end
        return v;
    endfunction

    // Mostly moderate magnitudes so every limiter outcome is common
    function automatic face_t rand_face();
        face_t f;
        int mb;
        f.flux_pos = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: f.weight = WEIGHT_W'($urandom_range(0, 131071));
            1: f.weight = ($urandom_range(0, 1) == 1) ? WEIGHT_ONE : '0;
            default: f.weight = WEIGHT_W'($urandom_range(0, 65536));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 7; i++) f.vecs[i] = rand_vec(CW);
        end else begin
            mb = $urandom_range(4, 19);
            for (int i = 0; i < 4; i++) f.vecs[i] = rand_vec(mb);
            mb = $urandom_range(6, 14);
            for (int i = 4; i < 7; i++) f.vecs[i] = rand_vec(mb);
        end
        return f;
    endfunction

    // Receiver: randomly switching stall patterns, plus long hold-off
    always @(posedge aclk) begin
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= (stall_count % 8 < 5);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: word accepted at the next rising edge
    always @(negedge aclk) begin
        corr_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_corr.size() == 0) begin
                $display("%0t: unexpected word data=%h kind=%0d", $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                e = expected_corr.pop_front();
                if (m_tdata !== e.corr) begin
                    $display("%0t: correction expected %h actual %h", $time, e.corr, m_tdata);
                    error_count++;
                end
                if (m_tuser !== e.kind) begin
                    $display("%0t: clip kind expected %0d actual %0d",
                             $time, e.kind, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Extremes, weight limits and each limiter outcome
    task automatic test_directed();
        face_t f;
        logic [VEC_W-1:0] ident[3];
        ident[0] = vec3(1024, 0, 0);
        ident[1] = vec3(0, 1024, 0);
        ident[2] = vec3(0, 0, 1024);
        // all zero, all ones, extremes
        f.flux_pos = 0; f.weight = '0; f.vecs = '0;
        send_face(f);
        f.flux_pos = 1; f.weight = '1; f.vecs = '1;
        send_face(f);
        for (int i = 0; i < 7; i++) f.vecs[i] = vec3(1048575, 1048575, 1048575);
        f.vecs[3] = vec3(-1048576, -1048576, -1048576);
        send_face(f);
        for (int i = 0; i < 7; i++) f.vecs[i] = vec3(-1048576, -1048576, -1048576);
        f.vecs[3] = vec3(1048575, 1048575, 1048575);
        f.flux_pos = 0;
        send_face(f);
        // identity gradient, c = (1, 0, 0)
        for (int k = 0; k < 8; k++) begin
            f.flux_pos = k[0];
            f.weight = (k[2:1] == 0) ? 17'd0 : (k[2:1] == 1) ? WEIGHT_ONE :
                       (k[2:1] == 2) ? 17'h1FFFF : 17'd32768;
            f.vecs[0] = '0;
            f.vecs[1] = vec3(-2048, 0, 0);
            f.vecs[2] = vec3(1024, 0, 0);
            f.vecs[3] = '0;
            for (int i = 0; i < 3; i++) f.vecs[4 + i] = ident[i];
            send_face(f);
            f.vecs[1] = vec3(512, 300, -7);
            send_face(f);
            f.vecs[1] = vec3(4096, 0, 0);
            f.vecs[0] = vec3(-4096, 0, 0);
            send_face(f);
        end
        // face copied from upwind, then the z sign bit of face and gx set
        f.vecs[2] = f.vecs[3];
        f.vecs[2][VEC_W-1] = 1'b1;
        f.vecs[4][VEC_W-1] = 1'b1;
        send_face(f);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) max_gap = $urandom_range(0, 1) ? 0 : 6;
            send_face(rand_face());
        end
    endtask

    // Long receiver hold-off while faces keep coming
    task automatic test_backpressure();
        max_gap = 0;
        burst_left = 100;
        hold_cycles = 300;
        for (int i = 0; i < 80; i++) send_face(rand_face());
        max_gap = 6;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_random(900);
        s_tvalid <= 1'b0;
        while (expected_corr.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule

### limited_linear_upwind_face_correction_unit.f
+incdir+hw/rtl
hw/rtl/llu_pkg.sv
hw/rtl/limited_linear_upwind_face_correction_unit.sv
tb/limited_linear_upwind_face_correction_unit_test.sv
